>>> design/sdtd_pkg.sv
// Package for the slow-data text deframer.
// Holds the sync pattern, header and descrambling constants and message sizes.
// No dependencies.
`default_nettype none

package sdtd_pkg;

  localparam int unsigned TEXT_LEN = 20;
  localparam int unsigned IDX_W    = 5;

  localparam logic [7:0] SYNC_FC = 8'h00;
  localparam logic [7:0] SYNC_A  = 8'h55;
  localparam logic [7:0] SYNC_B  = 8'h2D;
  localparam logic [7:0] SYNC_C  = 8'h16;

  localparam logic [7:0] HDR_BASE = 8'h30;

  localparam logic [7:0] SCR_A = 8'h70;
  localparam logic [7:0] SCR_B = 8'h4F;
  localparam logic [7:0] SCR_C = 8'h93;

  localparam logic [3:0] FIRST_STEP = 4'd1;
  localparam logic [3:0] LAST_STEP  = 4'd8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TEXT_LEN - 1);

endpackage

`default_nettype wire

>>> design/slow_data_text_deframer.sv
// Top level of the slow-data text deframer.
// Depends on sdtd_pkg for constants; holds the 20-byte text memory itself.
//
// Usage:
//   The input channel (in_valid / in_ready) takes one voice frame per word:
//   its frame counter and three slow-data bytes. A frame with counter 0 and
//   the sync bytes 55 2D 16 arms the deframer; frames 1 to 8 must then follow
//   in order, each adding two or three descrambled text bytes to the memory.
//   Frames that do not fit the expected step are dropped without effect.
//   When frame 8 is taken, the output channel (out_valid / out_ready) gives
//   the 20 text bytes in index order, one word each, with out_last_char set
//   on the twentieth.
//   A frame that does not write text is taken directly in the idle state. A
//   text frame is accepted and then its bytes (2 or 3) are written one at a
//   time, as the text memory has a single write port. The readout of a
//   complete message steps through two states per byte, one to issue the
//   memory read and one to present the registered read data. in_ready is
//   low while writing or reading out, so writes and reads of the memory
//   never overlap.
//   Reset disarms the deframer; the text memory is not cleared, since every
//   entry is written before a complete message is read. When the receiver
//   stalls, the current byte holds on the outputs and the readout waits.
`default_nettype none

module slow_data_text_deframer
  import sdtd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_frame_counter,
  input  wire logic [7:0]       in_slow_byte_a,
  input  wire logic [7:0]       in_slow_byte_b,
  input  wire logic [7:0]       in_slow_byte_c,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [IDX_W-1:0]      out_char_index,
  output logic [7:0]            out_char_value,
  output logic                  out_last_char
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_SHOW
  } state_t;

  // Control state.
  state_t           state_r, state_nxt;
  logic             armed_r, armed_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [1:0]       wcnt_r, wcnt_nxt;
  logic [1:0]       wlast_r, wlast_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  // Payload of the frame being written.
  logic [7:0]       wv0_r, wv1_r, wv2_r;
  logic [IDX_W-1:0] wbase_r;

  // Text memory and its registered read port.
  logic [7:0]       text_mem_r [TEXT_LEN];
  logic [7:0]       rd_data_r;

  // Frame decode.
  logic             accept;
  logic             is_sync;
  logic             step_hit;
  logic             odd_step;
  logic [3:0]       step_m1;
  logic [1:0]       pair;
  logic             hdr_ok;
  logic             take;
  logic             complete;
  logic [IDX_W-1:0] base;
  logic [7:0]       dv0, dv1, dv2;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign is_sync  = (in_frame_counter == SYNC_FC) && (in_slow_byte_a == SYNC_A) &&
                    (in_slow_byte_b == SYNC_B) && (in_slow_byte_c == SYNC_C);
  assign step_hit = armed_r && (in_frame_counter == {4'd0, step_r});
  assign odd_step = step_r[0];
  assign step_m1  = step_r - 4'd1;
  // Odd and even steps of the same pair share (step - 1) / 2.
  assign pair     = step_m1[2:1];
  assign hdr_ok   = !odd_step || (in_slow_byte_a == (HDR_BASE + {6'd0, pair}));
  assign take     = step_hit && hdr_ok;
  assign complete = !odd_step && (step_r == LAST_STEP);

  // Each pair of frames carries five bytes: two on the odd frame, three on
  // the even one.
  assign base = {1'b0, pair, 2'b00} + {3'd0, pair} + (odd_step ? IDX_W'(0) : IDX_W'(2));

  always_comb begin
    if (odd_step) begin
      dv0 = in_slow_byte_b ^ SCR_B;
      dv1 = in_slow_byte_c ^ SCR_C;
      dv2 = 8'h00;
    end else begin
      dv0 = in_slow_byte_a ^ SCR_A;
      dv1 = in_slow_byte_b ^ SCR_B;
      dv2 = in_slow_byte_c ^ SCR_C;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    armed_nxt  = armed_r;
    step_nxt   = step_r;
    wcnt_nxt   = wcnt_r;
    wlast_nxt  = wlast_r;
    done_nxt   = done_r;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_sync) begin
            // Sync restarts the message; stale bytes get overwritten later.
            armed_nxt = 1'b1;
            step_nxt  = FIRST_STEP;
          end else if (take) begin
            wcnt_nxt  = 2'd0;
            wlast_nxt = odd_step ? 2'd1 : 2'd2;
            done_nxt  = complete;
            state_nxt = ST_WRITE;
            if (complete) begin
              armed_nxt = 1'b0;
              step_nxt  = 4'd0;
            end else begin
              step_nxt = step_r + 4'd1;
            end
          end
        end
      end
      ST_WRITE: begin
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == wlast_r) begin
          if (done_r) begin
            rd_idx_nxt = '0;
            state_nxt  = ST_RD_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD_ISSUE: begin
        state_nxt = ST_RD_SHOW;
      end
      ST_RD_SHOW: begin
        if (out_ready) begin
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
            state_nxt  = ST_RD_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      armed_r  <= 1'b0;
      step_r   <= 4'd0;
      wcnt_r   <= 2'd0;
      wlast_r  <= 2'd0;
      done_r   <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      armed_r  <= armed_nxt;
      step_r   <= step_nxt;
      wcnt_r   <= wcnt_nxt;
      wlast_r  <= wlast_nxt;
      done_r   <= done_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) begin
      wv0_r   <= dv0;
      wv1_r   <= dv1;
      wv2_r   <= dv2;
      wbase_r <= base;
    end
  end

  // One byte per cycle goes into the memory while in the write state.
  assign wr_en   = (state_r == ST_WRITE);
  assign wr_addr = wbase_r + {3'd0, wcnt_r};
  assign rd_en   = (state_r == ST_RD_ISSUE);

  always_comb begin
    case (wcnt_r)
      2'd0:    wr_data = wv0_r;
      2'd1:    wr_data = wv1_r;
      2'd2:    wr_data = wv2_r;
      default: wr_data = wv0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= text_mem_r[rd_idx_r];
    end
  end

  assign out_valid      = (state_r == ST_RD_SHOW);
  assign out_char_index = rd_idx_r;
  assign out_char_value = rd_data_r;
  assign out_last_char  = (rd_idx_r == LAST_IDX);

  // The step is 1 to 8 exactly while armed.
  a_step_armed: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (step_r >= FIRST_STEP && step_r <= LAST_STEP))
    else $error("step out of range while armed");

  a_step_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (step_r == 4'd0))
    else $error("step not cleared while disarmed");

  // Writes stay within the frame's byte count and the memory.
  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wcnt_r <= wlast_r && wr_addr <= LAST_IDX))
    else $error("text write out of bounds");

  // Readout only starts after a completed message has been written.
  a_read_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && state_nxt == ST_RD_ISSUE) |-> done_r && !armed_r)
    else $error("readout started without a complete message");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!in_ready && rd_idx_r <= LAST_IDX))
    else $error("input taken during readout");

endmodule

`default_nettype wire
